>>> sv/mbaq_pkg.sv
// shared types and constants for the memory budget admission queue
package mbaq_pkg;

    localparam int SIZE_W     = 16;
    localparam int CAP_W      = 16;
    localparam int PAR_W      = 5;
    localparam int CNT_OUT_W  = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'd1024;
    localparam logic [PAR_W-1:0] PAR_RESET = 5'd4;

    typedef enum logic [1:0] {
        FN_CREATE = 2'd0,
        FN_KILL   = 2'd1,
        FN_CLEAR  = 2'd2,
        FN_BAD    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_ADMITTED     = 3'd0,
        ST_QUEUED       = 3'd1,
        ST_TOO_LARGE    = 3'd2,
        ST_WAIT_FULL    = 3'd3,
        ST_KILLED       = 3'd4,
        ST_NONE_RUNNING = 3'd5,
        ST_CLEARED      = 3'd6,
        ST_BAD_FUNC     = 3'd7
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MEMORY_CAPACITY = 1'b0,
        REG_MAX_PARALLEL    = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic clr;
        logic push;
        logic pop;
    } fifo_cmd_t;

endpackage

>>> sv/mbaq_fifo.sv
// job fifo with memory storage and a registered head entry
module mbaq_fifo #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mbaq_pkg::fifo_cmd_t         cmd,
    input  logic [DATA_W-1:0]           wdata,
    output logic [DATA_W-1:0]           head_data,
    output logic [$clog2(DEPTH+1)-1:0]  count,
    output logic [$clog2(DEPTH+1)-1:0]  count_next
);
    import mbaq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [AW-1:0]     tail_reg;
    logic [AW-1:0]     tail_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     cnt_next;
    logic              do_push;
    logic              do_pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + AW'(1);
        end
        return r;
    endfunction

    assign do_push = cmd.push && !cmd.clr;
    assign do_pop  = cmd.pop && !cmd.clr;

    always_comb begin
        if (cmd.clr) begin
            head_next = '0;
            tail_next = '0;
            cnt_next  = '0;
        end else begin
            head_next = do_pop ? ptr_inc(head_reg) : head_reg;
            tail_next = do_push ? ptr_inc(tail_reg) : tail_reg;
            cnt_next  = count_reg + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= cnt_next;
        end
    end

    // head entry follows the next head pointer, bypassing a same-cycle write
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[tail_reg] <= wdata;
        end
        if (do_push && (tail_reg == head_next)) begin
            rdata_reg <= wdata;
        end else begin
            rdata_reg <= mem[head_next];
        end
    end

    assign head_data  = rdata_reg;
    assign count      = count_reg;
    assign count_next = cnt_next;

endmodule

>>> sv/mbaq_ctrl.sv
// admission decision for create, kill and clear requests
module mbaq_ctrl #(
    parameter int RUN_DEPTH  = 16,
    parameter int WAIT_DEPTH = 16,
    parameter int MEM_BITS   = 16,
    parameter int ID_BITS    = 16
) (
    input  logic                                    en,
    input  mbaq_pkg::func_t                         func,
    input  logic [ID_BITS-1:0]                      job_id,
    input  logic [mbaq_pkg::SIZE_W-1:0]             job_size,
    input  logic [mbaq_pkg::CAP_W-1:0]              mem_cap,
    input  logic [mbaq_pkg::PAR_W-1:0]              max_par,
    input  logic [MEM_BITS-1:0]                     free_mem,
    input  logic [$clog2(RUN_DEPTH+1)-1:0]          run_count,
    input  logic [$clog2(WAIT_DEPTH+1)-1:0]         wait_count,
    input  logic [ID_BITS+mbaq_pkg::SIZE_W-1:0]     run_head,
    input  logic [ID_BITS+mbaq_pkg::SIZE_W-1:0]     wait_head,
    output mbaq_pkg::fifo_cmd_t                     run_cmd,
    output mbaq_pkg::fifo_cmd_t                     wait_cmd,
    output logic [ID_BITS+mbaq_pkg::SIZE_W-1:0]     run_wdata,
    output logic [ID_BITS+mbaq_pkg::SIZE_W-1:0]     wait_wdata,
    output logic [MEM_BITS-1:0]                     free_next,
    output mbaq_pkg::status_t                       status,
    output logic [ID_BITS-1:0]                      killed_id,
    output logic                                    promoted,
    output logic [ID_BITS-1:0]                      promoted_id
);
    import mbaq_pkg::*;

    localparam int RCW   = $clog2(RUN_DEPTH + 1);
    localparam int WCW   = $clog2(WAIT_DEPTH + 1);
    localparam int PW    = (RCW > PAR_W) ? RCW : PAR_W;
    localparam int CMP_W = ((MEM_BITS > SIZE_W) ? MEM_BITS : SIZE_W) + 1;

    logic [CMP_W-1:0]  ret_sum;
    logic [MEM_BITS-1:0] free_kill;
    logic [SIZE_W-1:0] run_head_size;
    logic [SIZE_W-1:0] wait_head_size;
    logic              run_room;
    logic              job_fits;
    logic              wait_full;
    logic              can_promote;
    fifo_cmd_t         run_c;
    fifo_cmd_t         wait_c;

    assign run_head_size  = run_head[SIZE_W-1:0];
    assign wait_head_size = wait_head[SIZE_W-1:0];

    assign run_room  = (run_count < RCW'(RUN_DEPTH)) && (PW'(run_count) < PW'(max_par));
    assign job_fits  = CMP_W'(job_size) <= CMP_W'(free_mem);
    assign wait_full = wait_count >= WCW'(WAIT_DEPTH);

    // returned memory saturates at all ones
    assign ret_sum   = CMP_W'(free_mem) + CMP_W'(run_head_size);
    assign free_kill = (ret_sum > CMP_W'({MEM_BITS{1'b1}})) ? {MEM_BITS{1'b1}}
                                                            : MEM_BITS'(ret_sum);
    assign can_promote = (wait_count != '0) &&
                         (CMP_W'(wait_head_size) <= CMP_W'(free_kill));

    always_comb begin
        run_c       = '0;
        wait_c      = '0;
        run_wdata   = {job_id, job_size};
        wait_wdata  = {job_id, job_size};
        free_next   = free_mem;
        status      = ST_BAD_FUNC;
        killed_id   = '0;
        promoted    = 1'b0;
        promoted_id = '0;
        case (func)
            FN_CREATE: begin
                if (job_size > mem_cap) begin
                    status = ST_TOO_LARGE;
                end else if (job_fits && run_room) begin
                    run_c.push = 1'b1;
                    free_next  = free_mem - MEM_BITS'(job_size);
                    status     = ST_ADMITTED;
                end else if (wait_full) begin
                    status = ST_WAIT_FULL;
                end else begin
                    wait_c.push = 1'b1;
                    status      = ST_QUEUED;
                end
            end
            FN_KILL: begin
                if (run_count == '0) begin
                    status = ST_NONE_RUNNING;
                end else begin
                    run_c.pop = 1'b1;
                    killed_id = run_head[ID_BITS+SIZE_W-1:SIZE_W];
                    free_next = free_kill;
                    status    = ST_KILLED;
                    if (can_promote) begin
                        wait_c.pop  = 1'b1;
                        run_c.push  = 1'b1;
                        run_wdata   = wait_head;
                        free_next   = free_kill - MEM_BITS'(wait_head_size);
                        promoted    = 1'b1;
                        promoted_id = wait_head[ID_BITS+SIZE_W-1:SIZE_W];
                    end
                end
            end
            FN_CLEAR: begin
                run_c.clr  = 1'b1;
                wait_c.clr = 1'b1;
                status     = ST_CLEARED;
            end
            default: begin
                status = ST_BAD_FUNC;
            end
        endcase
    end

    assign run_cmd  = en ? run_c : '0;
    assign wait_cmd = en ? wait_c : '0;

endmodule

>>> sv/memory_budget_admission_queue.sv
// top level: request register, admission logic, job fifos and result register
// a request enters the request register; its result and the queue update are made
// when the result register is empty or being read
// throughput: one request per cycle unless the result output stalls
// reset: clears the pointers, counts and handshake state, capacity to 1024 MB,
// the running cap to 4 and free memory to the capacity; queue storage is not cleared
module memory_budget_admission_queue #(
    parameter int RUN_DEPTH  = 16,
    parameter int WAIT_DEPTH = 16,
    parameter int MEM_BITS   = 16,
    parameter int ID_BITS    = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [mbaq_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [mbaq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_func,
    input  logic [ID_BITS-1:0]                  s_job_id,
    input  logic [mbaq_pkg::SIZE_W-1:0]         s_job_size,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mbaq_pkg::status_t                   m_status,
    output logic [ID_BITS-1:0]                  m_killed_id,
    output logic                                m_promoted,
    output logic [ID_BITS-1:0]                  m_promoted_id,
    output logic [MEM_BITS-1:0]                 m_free_memory,
    output logic [mbaq_pkg::CNT_OUT_W-1:0]      m_running_count,
    output logic [mbaq_pkg::CNT_OUT_W-1:0]      m_waiting_count
);
    import mbaq_pkg::*;

    localparam int RCW    = $clog2(RUN_DEPTH + 1);
    localparam int WCW    = $clog2(WAIT_DEPTH + 1);
    localparam int ENTRY_W = ID_BITS + SIZE_W;

    logic                 in_valid_reg;
    func_t                func_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic                 advance;
    logic                 fire;

    logic [CAP_W-1:0]     mem_cap_reg;
    logic [PAR_W-1:0]     max_par_reg;
    logic [MEM_BITS-1:0]  free_mem_reg;

    fifo_cmd_t            run_cmd;
    fifo_cmd_t            wait_cmd;
    logic [ENTRY_W-1:0]   run_wdata;
    logic [ENTRY_W-1:0]   wait_wdata;
    logic [ENTRY_W-1:0]   run_head;
    logic [ENTRY_W-1:0]   wait_head;
    logic [RCW-1:0]       run_count;
    logic [RCW-1:0]       run_count_next;
    logic [WCW-1:0]       wait_count;
    logic [WCW-1:0]       wait_count_next;

    logic [MEM_BITS-1:0]  free_next;
    status_t              status;
    logic [ID_BITS-1:0]   killed_id;
    logic                 promoted;
    logic [ID_BITS-1:0]   promoted_id;

    logic                 m_valid_reg;
    status_t              status_reg;
    logic [ID_BITS-1:0]   killed_id_reg;
    logic                 promoted_reg;
    logic [ID_BITS-1:0]   promoted_id_reg;
    logic [MEM_BITS-1:0]  free_out_reg;
    logic [CNT_OUT_W-1:0] run_out_reg;
    logic [CNT_OUT_W-1:0] wait_out_reg;

    assign advance = !m_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg <= func_t'(s_func);
            id_reg   <= s_job_id;
            size_reg <= s_job_size;
        end
    end

    // configuration and free memory
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_cap_reg  <= CAP_RESET;
            max_par_reg  <= PAR_RESET;
            free_mem_reg <= MEM_BITS'(CAP_RESET);
        end else if (cfg_wen) begin
            case (cfg_reg_t'(cfg_idx))
                REG_MEMORY_CAPACITY: begin
                    mem_cap_reg  <= cfg_wdata[CAP_W-1:0];
                    free_mem_reg <= MEM_BITS'(cfg_wdata[CAP_W-1:0]);
                end
                REG_MAX_PARALLEL: begin
                    max_par_reg <= cfg_wdata[PAR_W-1:0];
                end
                default: begin
                    max_par_reg <= max_par_reg;
                end
            endcase
        end else if (fire) begin
            if (run_cmd.clr) begin
                free_mem_reg <= MEM_BITS'(mem_cap_reg);
            end else begin
                free_mem_reg <= free_next;
            end
        end
    end

    mbaq_ctrl #(
        .RUN_DEPTH  (RUN_DEPTH),
        .WAIT_DEPTH (WAIT_DEPTH),
        .MEM_BITS   (MEM_BITS),
        .ID_BITS    (ID_BITS)
    ) u_ctrl (
        .en          (fire),
        .func        (func_reg),
        .job_id      (id_reg),
        .job_size    (size_reg),
        .mem_cap     (mem_cap_reg),
        .max_par     (max_par_reg),
        .free_mem    (free_mem_reg),
        .run_count   (run_count),
        .wait_count  (wait_count),
        .run_head    (run_head),
        .wait_head   (wait_head),
        .run_cmd     (run_cmd),
        .wait_cmd    (wait_cmd),
        .run_wdata   (run_wdata),
        .wait_wdata  (wait_wdata),
        .free_next   (free_next),
        .status      (status),
        .killed_id   (killed_id),
        .promoted    (promoted),
        .promoted_id (promoted_id)
    );

    mbaq_fifo #(
        .DEPTH  (RUN_DEPTH),
        .DATA_W (ENTRY_W)
    ) u_run_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (run_cmd),
        .wdata      (run_wdata),
        .head_data  (run_head),
        .count      (run_count),
        .count_next (run_count_next)
    );

    mbaq_fifo #(
        .DEPTH  (WAIT_DEPTH),
        .DATA_W (ENTRY_W)
    ) u_wait_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (wait_cmd),
        .wdata      (wait_wdata),
        .head_data  (wait_head),
        .count      (wait_count),
        .count_next (wait_count_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            status_reg      <= status;
            killed_id_reg   <= killed_id;
            promoted_reg    <= promoted;
            promoted_id_reg <= promoted_id;
            free_out_reg    <= run_cmd.clr ? MEM_BITS'(mem_cap_reg) : free_next;
            run_out_reg     <= CNT_OUT_W'(run_count_next);
            wait_out_reg    <= CNT_OUT_W'(wait_count_next);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_killed_id     = killed_id_reg;
    assign m_promoted      = promoted_reg;
    assign m_promoted_id   = promoted_id_reg;
    assign m_free_memory   = free_out_reg;
    assign m_running_count = run_out_reg;
    assign m_waiting_count = wait_out_reg;

`ifndef SYNTHESIS
    a_run_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_count <= RCW'(RUN_DEPTH))
        else $error("running count above depth");

    a_wait_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wait_count <= WCW'(WAIT_DEPTH))
        else $error("waiting count above depth");

    a_kill_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (status_reg != ST_KILLED)) |->
        (killed_id_reg == '0) && !promoted_reg && (promoted_id_reg == '0))
        else $error("kill fields set without a kill");

    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(func_reg)))
        else $error("stalled request lost");
`endif

endmodule

>>> sim/memory_budget_admission_queue_tb.sv
// testbench for the memory budget admission queue: directed and random requests checked against a predictor
module memory_budget_admission_queue_tb;
    import mbaq_pkg::*;

    localparam int PERIOD         = 12;
    localparam int RUN_SLOTS      = 16;
    localparam int WAIT_SLOTS     = 16;
    localparam int HOLD_CYCLES    = 120;
    localparam int TIMEOUT_CYCLES = 200000;

    typedef struct {
        func_t       fn;
        logic [15:0] id;
        logic [15:0] size;
    } request_t;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] size;
    } job_t;

    typedef struct {
        status_t     status;
        logic [15:0] killed_id;
        logic        promoted;
        logic [15:0] promoted_id;
        logic [15:0] free_mb;
        logic [4:0]  running;
        logic [4:0]  waiting;
    } outcome_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = REG_MEMORY_CAPACITY;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_func = FN_CREATE;
    logic [15:0] s_job_id = '0;
    logic [15:0] s_job_size = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    status_t m_status;
    logic [15:0] m_killed_id;
    logic m_promoted;
    logic [15:0] m_promoted_id;
    logic [15:0] m_free_memory;
    logic [4:0] m_running_count;
    logic [4:0] m_waiting_count;

    request_t queued_requests[$];
    outcome_t awaited_outcomes[$];
    request_t next_req;

    job_t running_jobs[$];
    job_t waiting_jobs[$];
    logic [15:0] budget_mb;
    logic [15:0] free_mb;
    logic [4:0] parallel_cap;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int stall_trigger = 0;
    int stall_seen = 0;
    int hold_left = 0;
    int mismatches = 0;

    memory_budget_admission_queue dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_idx         (cfg_idx),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_job_id        (s_job_id),
        .s_job_size      (s_job_size),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_killed_id     (m_killed_id),
        .m_promoted      (m_promoted),
        .m_promoted_id   (m_promoted_id),
        .m_free_memory   (m_free_memory),
        .m_running_count (m_running_count),
        .m_waiting_count (m_waiting_count)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    function automatic outcome_t compute_outcome(func_t fn, logic [15:0] id, logic [15:0] sz);
        outcome_t o;
        job_t j;
        int unsigned cap;
        int unsigned sum;
        o = '{ST_BAD_FUNC, 16'd0, 1'b0, 16'd0, 16'd0, 5'd0, 5'd0};
        cap = (parallel_cap < RUN_SLOTS) ? parallel_cap : RUN_SLOTS;
        case (fn)
            FN_CREATE: begin
                if (sz > budget_mb) begin
                    o.status = ST_TOO_LARGE;
                end else if (sz <= free_mb && running_jobs.size() < cap) begin
                    running_jobs.push_back({id, sz});
                    free_mb = free_mb - sz;
                    o.status = ST_ADMITTED;
                end else if (waiting_jobs.size() >= WAIT_SLOTS) begin
                    o.status = ST_WAIT_FULL;
                end else begin
                    waiting_jobs.push_back({id, sz});
                    o.status = ST_QUEUED;
                end
            end
            FN_KILL: begin
                if (running_jobs.size() == 0) begin
                    o.status = ST_NONE_RUNNING;
                end else begin
                    j = running_jobs.pop_front();
                    sum = free_mb + j.size;
                    free_mb = (sum > 32'hFFFF) ? 16'hFFFF : 16'(sum);
                    o.killed_id = j.id;
                    o.status = ST_KILLED;
                    // promotion only looks at memory, not the running cap
                    if (waiting_jobs.size() != 0 && waiting_jobs[0].size <= free_mb) begin
                        j = waiting_jobs.pop_front();
                        running_jobs.push_back(j);
                        free_mb = free_mb - j.size;
                        o.promoted = 1'b1;
                        o.promoted_id = j.id;
                    end
                end
            end
            FN_CLEAR: begin
                running_jobs.delete();
                waiting_jobs.delete();
                free_mb = budget_mb;
                o.status = ST_CLEARED;
            end
            FN_BAD: begin
            end
        endcase
        o.free_mb = free_mb;
        o.running = 5'(running_jobs.size());
        o.waiting = 5'(waiting_jobs.size());
        return o;
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
        end
    endfunction

    task automatic check_outcome();
        outcome_t e;
        if (awaited_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with nothing expected, status %0d", $realtime, m_status);
        end else begin
            e = awaited_outcomes.pop_front();
            compare_field("status", e.status, m_status);
            compare_field("killed_id", e.killed_id, m_killed_id);
            compare_field("promoted", e.promoted, m_promoted);
            compare_field("promoted_id", e.promoted_id, m_promoted_id);
            compare_field("free_memory", e.free_mb, m_free_memory);
            compare_field("running_count", e.running, m_running_count);
            compare_field("waiting_count", e.waiting, m_waiting_count);
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                awaited_outcomes.push_back(compute_outcome(func_t'(s_func), s_job_id, s_job_size));
            if (!s_valid || s_ready) begin
                if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = queued_requests.pop_front();
                    s_valid <= 1'b1;
                    s_func <= next_req.fn;
                    s_job_id <= next_req.id;
                    s_job_size <= next_req.size;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with its own long hold-off counter
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
            stall_seen <= 0;
        end else begin
            if (m_valid && m_ready)
                check_outcome();
            if (stall_seen != stall_trigger) begin
                stall_seen <= stall_trigger;
                hold_left <= HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic queue_req(func_t fn, logic [15:0] id, logic [15:0] sz);
        queued_requests.push_back('{fn, id, sz});
    endtask

    task automatic queue_random(int n, int kill_pct, int size_cap);
        request_t r;
        int pick;
        repeat (n) begin
            r.id = 16'($urandom);
            pick = $urandom_range(99);
            if (pick < 70)
                r.size = 16'($urandom_range(size_cap));
            else if (pick < 85)
                r.size = 16'($urandom);
            else
                r.size = 16'($urandom_range(3));
            pick = $urandom_range(99);
            if (pick < 2)
                r.fn = FN_BAD;
            else if (pick < 5)
                r.fn = FN_CLEAR;
            else if (pick < 5 + kill_pct)
                r.fn = FN_KILL;
            else
                r.fn = FN_CREATE;
            queued_requests.push_back(r);
        end
    endtask

    task automatic wait_quiet();
        do
            @(negedge aclk);
        while (queued_requests.size() != 0 || s_valid || awaited_outcomes.size() != 0);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        if (idx == REG_MEMORY_CAPACITY) begin
            budget_mb = val;
            free_mb = val;
        end else begin
            parallel_cap = val[4:0];
        end
        @(negedge aclk);
    endtask

    task automatic run_phase(logic [15:0] cap_mb, logic [4:0] par, int send_pct, int recv_pct,
                             int n, int kill_pct, int size_cap);
        write_reg(REG_MEMORY_CAPACITY, cap_mb);
        write_reg(REG_MAX_PARALLEL, 16'(par));
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        queue_random(n, kill_pct, size_cap);
        wait_quiet();
    endtask

    initial begin
        running_jobs.delete();
        waiting_jobs.delete();
        budget_mb = CAP_RESET;
        free_mb = CAP_RESET;
        parallel_cap = PAR_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: empty kill, bad func, zero size, exact fit, oversize
        queue_req(FN_KILL, 16'h0000, 16'h0000);
        queue_req(FN_BAD, 16'hFFFF, 16'hFFFF);
        queue_req(FN_CREATE, 16'h0000, 16'd0);
        queue_req(FN_CREATE, 16'hFFFF, 16'd1024);
        queue_req(FN_CREATE, 16'h0001, 16'd1025);
        queue_req(FN_CREATE, 16'h0002, 16'hFFFF);
        queue_req(FN_CREATE, 16'h0003, 16'd1);
        queue_req(FN_CREATE, 16'h0004, 16'd0);
        queue_req(FN_KILL, 16'h0000, 16'h0000);
        queue_req(FN_KILL, 16'hFFFF, 16'hFFFF);
        queue_req(FN_CLEAR, 16'h5A5A, 16'hA5A5);
        wait_quiet();

        // free memory saturation after a capacity rewrite with jobs running
        write_reg(REG_MEMORY_CAPACITY, 16'hFFFF);
        write_reg(REG_MAX_PARALLEL, 16'd16);
        queue_req(FN_CREATE, 16'h5555, 16'd60000);
        queue_req(FN_CREATE, 16'hAAAA, 16'hFFFF);
        wait_quiet();
        write_reg(REG_MEMORY_CAPACITY, 16'hFFFF);
        queue_req(FN_KILL, 16'h0000, 16'h0000);
        queue_req(FN_CREATE, 16'h1234, 16'd0);
        queue_req(FN_CLEAR, 16'h0000, 16'h0000);
        wait_quiet();

        run_phase(16'd1024, 5'd4, 0, 0, 130, 35, 1100);
        run_phase(16'd100, 5'd2, 82, 0, 130, 35, 110);
        run_phase(16'hFFFF, 5'd16, 0, 82, 130, 35, 16'hFFFF);
        // no running slots: everything waits until the waiting queue is full
        run_phase(16'd1, 5'd0, 8, 8, 130, 15, 2);
        // cap above the running depth
        run_phase(16'd50, 5'd31, 0, 0, 130, 20, 3);

        // receiver holds off while requests keep coming
        write_reg(REG_MEMORY_CAPACITY, 16'd500);
        write_reg(REG_MAX_PARALLEL, 16'd16);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        stall_trigger++;
        queue_random(130, 30, 80);
        wait_quiet();

        // sender pauses until every result is back, then resumes
        write_reg(REG_MEMORY_CAPACITY, 16'd2000);
        write_reg(REG_MAX_PARALLEL, 16'd3);
        send_idle_pct = 0;
        recv_stall_pct = 82;
        queue_random(60, 35, 900);
        wait_quiet();
        queue_random(70, 35, 900);
        wait_quiet();

        run_phase(16'hFFFF, 5'd1, 8, 8, 130, 35, 40000);

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && awaited_outcomes.size() == 0) begin
            $display("memory_budget_admission_queue_tb passed");
        end else begin
            $display("memory_budget_admission_queue_tb failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * PERIOD);
        $display("memory_budget_admission_queue_tb failed");
        $finish;
    end

endmodule

>>> sim.f
sv/mbaq_pkg.sv
sv/mbaq_fifo.sv
sv/mbaq_ctrl.sv
sv/memory_budget_admission_queue.sv
sim/memory_budget_admission_queue_tb.sv
